// ===== rtl/fcdma_pkg.sv =====
// ----------------------------------------------------------------------------
// fcdma_pkg
// Types, constants and helpers shared by the four channel dma controller.
// ----------------------------------------------------------------------------
package fcdma_pkg;

    localparam int CHANNELS = 4;

    typedef enum logic [2:0] {
        OP_SRC_WRITE  = 3'd0,
        OP_DST_WRITE  = 3'd1,
        OP_CNT_WRITE  = 3'd2,
        OP_CTL_WRITE  = 3'd3,
        OP_HBLANK     = 3'd4,
        OP_VBLANK     = 3'd5,
        OP_STEP       = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_UNIT = 2'd1,
        KIND_IDLE = 2'd2
    } t_kind;

    // timing field codes
    localparam logic [1:0] TIM_IMMEDIATE = 2'd0;
    localparam logic [1:0] TIM_VBLANK    = 2'd1;
    localparam logic [1:0] TIM_HBLANK    = 2'd2;

    // address mode codes
    localparam logic [1:0] AMODE_DEC    = 2'd1;
    localparam logic [1:0] AMODE_FIXED  = 2'd2;
    localparam logic [1:0] AMODE_RELOAD = 2'd3;

    // control word bits
    localparam int CTL_REPEAT = 9;
    localparam int CTL_WIDE   = 10;
    localparam int CTL_IRQ    = 14;
    localparam int CTL_ENABLE = 15;

    localparam logic [15:0] CTL_STORE_MASK  = 16'hFFE0;
    localparam logic [15:0] CTL_DISABLE_MSK = 16'h7FE0;
    localparam logic [31:0] ADDR_HALF_MASK  = 32'hFFFF_FFFE;
    localparam logic [31:0] ADDR_WORD_MASK  = 32'hFFFF_FFFC;
    localparam logic [16:0] COUNT_FULL      = 17'h04000;
    localparam logic [16:0] COUNT_FULL_CH3  = 17'h10000;

    typedef struct packed {
        t_op         opcode;
        logic [1:0]  channel;
        logic [31:0] write_data;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  channel;
        logic [31:0] read_address;
        logic [31:0] write_address;
        logic        word_unit;
        logic [15:0] control;
        logic        block_done;
        logic        irq_request;
    } t_result;

    function automatic logic [16:0] full_count(input int ch);
        return (ch == 3) ? COUNT_FULL_CH3 : COUNT_FULL;
    endfunction

    function automatic logic [31:0] addr_step(input logic [1:0] mode, input logic wide);
        logic [31:0] w;
        w = wide ? 32'd4 : 32'd2;
        if (mode == AMODE_DEC) begin
            return 32'd0 - w;
        end else if (mode == AMODE_FIXED) begin
            return 32'd0;
        end
        return w;
    endfunction

endpackage

// ===== rtl/fcdma_in_stage.sv =====
// ----------------------------------------------------------------------------
// fcdma_in_stage
// Input register: captures one transaction and holds it until executed.
// ----------------------------------------------------------------------------
module fcdma_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fcdma_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output fcdma_pkg::t_item o_item
);
    import fcdma_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/fcdma_exec.sv =====
// ----------------------------------------------------------------------------
// fcdma_exec
// Channel register file and single-pass execution of one transaction.
// ----------------------------------------------------------------------------
module fcdma_exec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  fcdma_pkg::t_item   i_item,
    output fcdma_pkg::t_result o_result
);
    import fcdma_pkg::*;

    logic [31:0] r_start_src [CHANNELS];
    logic [31:0] r_start_dst [CHANNELS];
    logic [16:0] r_count     [CHANNELS];
    logic [31:0] r_cur_src   [CHANNELS];
    logic [31:0] r_cur_dst   [CHANNELS];
    logic [16:0] r_units     [CHANNELS];
    logic [15:0] r_ctl       [CHANNELS];
    logic        r_pend      [CHANNELS];

    logic [31:0] n_start_src [CHANNELS];
    logic [31:0] n_start_dst [CHANNELS];
    logic [16:0] n_count     [CHANNELS];
    logic [31:0] n_cur_src   [CHANNELS];
    logic [31:0] n_cur_dst   [CHANNELS];
    logic [16:0] n_units     [CHANNELS];
    logic [15:0] n_ctl       [CHANNELS];
    logic        n_pend      [CHANNELS];

    t_result     res;
    logic        found;
    logic        wide;
    logic [31:0] amask;
    logic [31:0] src;
    logic [31:0] dst;
    logic [16:0] left;
    logic [15:0] ctl_new;

    assign o_result = res;

    always_comb begin
        n_start_src = r_start_src;
        n_start_dst = r_start_dst;
        n_count     = r_count;
        n_cur_src   = r_cur_src;
        n_cur_dst   = r_cur_dst;
        n_units     = r_units;
        n_ctl       = r_ctl;
        n_pend      = r_pend;
        res         = '0;
        res.kind    = KIND_ACK;
        found       = 1'b0;
        wide        = 1'b0;
        amask       = ADDR_HALF_MASK;
        src         = '0;
        dst         = '0;
        left        = '0;
        ctl_new     = i_item.write_data[15:0] & CTL_STORE_MASK;

        case (i_item.opcode)
            OP_SRC_WRITE, OP_DST_WRITE, OP_CNT_WRITE, OP_CTL_WRITE: begin
                res.channel = i_item.channel;
                if (i_item.opcode == OP_CTL_WRITE) begin
                    res.control = ctl_new;
                end
                for (int k = 0; k < CHANNELS; k++) begin
                    if (32'(i_item.channel) == k) begin
                        case (i_item.opcode)
                            OP_SRC_WRITE: begin
                                n_start_src[k] = i_item.write_data & ADDR_HALF_MASK;
                            end
                            OP_DST_WRITE: begin
                                n_start_dst[k] = i_item.write_data & ADDR_HALF_MASK;
                            end
                            OP_CNT_WRITE: begin
                                n_count[k] = (i_item.write_data[15:0] == 16'd0)
                                    ? full_count(k) : {1'b0, i_item.write_data[15:0]};
                            end
                            default: begin
                                n_ctl[k] = ctl_new;
                                if (!ctl_new[CTL_ENABLE]) begin
                                    n_pend[k] = 1'b0;
                                end else if (!r_ctl[k][CTL_ENABLE]) begin
                                    n_cur_src[k] = r_start_src[k];
                                    n_cur_dst[k] = r_start_dst[k];
                                    n_units[k]   = (r_count[k] == 17'd0)
                                        ? full_count(k) : r_count[k];
                                    n_pend[k]    = (ctl_new[13:12] == TIM_IMMEDIATE);
                                end
                            end
                        endcase
                    end
                end
            end
            OP_HBLANK, OP_VBLANK: begin
                for (int k = 0; k < CHANNELS; k++) begin
                    if (r_ctl[k][CTL_ENABLE] && (r_ctl[k][13:12] ==
                        ((i_item.opcode == OP_HBLANK) ? TIM_HBLANK : TIM_VBLANK))) begin
                        n_pend[k] = 1'b1;
                    end
                end
            end
            OP_STEP: begin
                // lowest pending, enabled channel wins
                for (int k = 0; k < CHANNELS; k++) begin
                    if (!found && r_pend[k] && r_ctl[k][CTL_ENABLE]) begin
                        found = 1'b1;
                        wide  = r_ctl[k][CTL_WIDE];
                        amask = wide ? ADDR_WORD_MASK : ADDR_HALF_MASK;
                        src   = r_cur_src[k] & amask;
                        dst   = r_cur_dst[k] & amask;
                        left  = r_units[k] - 17'd1;

                        res.kind          = KIND_UNIT;
                        res.channel       = 2'(k);
                        res.read_address  = src;
                        res.write_address = dst;
                        res.word_unit     = wide;

                        n_cur_src[k] = src + addr_step(r_ctl[k][8:7], wide);
                        n_cur_dst[k] = dst + addr_step(r_ctl[k][6:5], wide);
                        n_units[k]   = left;

                        if (left == 17'd0) begin
                            res.block_done  = 1'b1;
                            res.irq_request = r_ctl[k][CTL_IRQ];
                            n_pend[k]       = 1'b0;
                            if (r_ctl[k][CTL_REPEAT] && r_ctl[k][13:12] != TIM_IMMEDIATE) begin
                                n_units[k] = (r_count[k] == 17'd0)
                                    ? full_count(k) : r_count[k];
                                if (r_ctl[k][6:5] == AMODE_RELOAD) begin
                                    n_cur_dst[k] = r_start_dst[k];
                                end
                            end else begin
                                n_ctl[k] = r_ctl[k] & CTL_DISABLE_MSK;
                            end
                        end
                        res.control = n_ctl[k];
                    end
                end
                if (!found) begin
                    res.kind = KIND_IDLE;
                end
            end
            default: begin
                res.kind = KIND_ACK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_start_src[k] <= '0;
                r_start_dst[k] <= '0;
                r_count[k]     <= '0;
                r_cur_src[k]   <= '0;
                r_cur_dst[k]   <= '0;
                r_units[k]     <= '0;
                r_ctl[k]       <= '0;
                r_pend[k]      <= 1'b0;
            end
        end else if (i_fire) begin
            r_start_src <= n_start_src;
            r_start_dst <= n_start_dst;
            r_count     <= n_count;
            r_cur_src   <= n_cur_src;
            r_cur_dst   <= n_cur_dst;
            r_units     <= n_units;
            r_ctl       <= n_ctl;
            r_pend      <= n_pend;
        end
    end

endmodule

// ===== rtl/fcdma_out_stage.sv =====
// ----------------------------------------------------------------------------
// fcdma_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module fcdma_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  fcdma_pkg::t_result i_result,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output fcdma_pkg::t_result o_result
);
    import fcdma_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/four_channel_dma_controller.sv =====
// ----------------------------------------------------------------------------
// four_channel_dma_controller
// Four dma channels driven by register writes, blank events and step requests.
// ----------------------------------------------------------------------------
// Every transaction (register write, hblank, vblank or step) gives exactly one
// result. A transaction is taken into an input register, executed against the
// channel registers combinationally and lands in a result register; a new
// transaction is taken every cycle as long as the result register drains. A
// step issues one 16- or 32-bit unit for the lowest numbered pending channel
// and reports its addresses, or an idle result if no channel is pending.
// Control writes echo the stored control word; a write of zero to count means
// 0x4000 units, or 0x10000 on channel 3. No clearing pass follows reset.
module four_channel_dma_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [1:0]  i_channel,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [1:0]  o_active_channel,
    output logic [31:0] o_read_address,
    output logic [31:0] o_write_address,
    output logic        o_word_unit,
    output logic [15:0] o_control_readback,
    output logic        o_block_done,
    output logic        o_irq_request
);
    import fcdma_pkg::*;

    t_item   in_item;
    t_item   exec_item;
    t_result exec_result;
    t_result out_result;
    logic    exec_valid;
    logic    out_can_load;
    logic    advance;

    assign in_item.opcode     = t_op'(i_opcode);
    assign in_item.channel    = i_channel;
    assign in_item.write_data = i_write_data;

    assign advance = exec_valid && out_can_load;

    fcdma_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (exec_valid),
        .o_item    (exec_item)
    );

    fcdma_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (exec_item),
        .o_result (exec_result)
    );

    fcdma_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (exec_result),
        .o_can_load (out_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_result_kind      = out_result.kind;
    assign o_active_channel   = out_result.channel;
    assign o_read_address     = out_result.read_address;
    assign o_write_address    = out_result.write_address;
    assign o_word_unit        = out_result.word_unit;
    assign o_control_readback = out_result.control;
    assign o_block_done       = out_result.block_done;
    assign o_irq_request      = out_result.irq_request;

endmodule
